FILE: hw/rtl/modular_exponentiation_unit_macros.svh
// assertion macros shared by the checker
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// same-cycle implication
`define MEXP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp check failed");

// next-cycle implication
`define MEXP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp check failed");

`endif

FILE: hw/rtl/mexp_pkg.sv
package mexp_pkg;

    localparam int FIELD_W   = 64;
    localparam int WIDTH_DEF = 64;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RED   = 6'b000010,
        S_CHECK = 6'b000100,
        S_MUL   = 6'b001000,
        S_SQR   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

FILE: hw/rtl/modular_exponentiation_unit.sv
// modular exponentiation unit: power_mod = base ^ exponent mod modulus
// input channel s_*: one word carries base, exponent and modulus; only the
// low WIDTH bits of each field take part
// output channel m_*: one word per input, power_mod zero-extended to 64 bits
// s_tready is high only while the sequencer is idle; one item at a time
// steps: modulus 0 or 1 gives 0 without using the multiplier; otherwise the
// base is first reduced mod modulus, then each exponent bit up to the
// highest set one costs one check, for a set bit one multiplication, and
// then one squaring; all of these run on the single shift-add modular
// multiplier, which retires one multiplier bit per cycle
// the result sits in an output register; a stalled receiver holds it there
// while the next word is already accepted, and the finished result after it
// waits in the sequencer until the register frees up
// reset (rst_n, asynchronous, active low) drops m_tvalid and returns the
// sequencer to idle
module modular_exponentiation_unit #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [3*mexp_pkg::FIELD_W-1:0] s_tdata,  // base, exponent, modulus
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mexp_pkg::FIELD_W-1:0]   m_tdata   // power_mod
);

    mexp_pkg::state_t state_reg, state_next;

    logic [WIDTH-1:0] res_reg,  res_next;
    logic [WIDTH-1:0] pow_reg,  pow_next;
    logic [WIDTH-1:0] exp_reg,  exp_next;
    logic [WIDTH-1:0] mod_reg,  mod_next;
    logic [WIDTH-1:0] out_reg,  out_next;
    logic             oval_reg, oval_next;

    logic [WIDTH-1:0] base_in;
    logic [WIDTH-1:0] exp_in;
    logic [WIDTH-1:0] mod_in;

    logic             mm_start;
    logic [WIDTH-1:0] mm_addend;
    logic [WIDTH-1:0] mm_mult;
    logic [WIDTH-1:0] mm_mod;
    logic             mm_done;
    logic [WIDTH-1:0] mm_product;

    assign base_in = s_tdata[WIDTH-1:0];
    assign exp_in  = s_tdata[mexp_pkg::FIELD_W +: WIDTH];
    assign mod_in  = s_tdata[2*mexp_pkg::FIELD_W +: WIDTH];

    assign s_tready = (state_reg == mexp_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        pow_next   = pow_reg;
        exp_next   = exp_reg;
        mod_next   = mod_reg;
        out_next   = out_reg;
        oval_next  = oval_reg;
        mm_start   = 1'b0;
        mm_addend  = pow_reg;
        mm_mult    = pow_reg;
        mm_mod     = mod_reg;

        if (oval_reg && m_tready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            mexp_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mod_next = mod_in;
                    exp_next = exp_in;
                    if (mod_in <= WIDTH'(1))
                    begin
                        res_next   = '0;
                        state_next = mexp_pkg::S_DONE;
                    end
                    else
                    begin
                        // base mod m as (1 * base) mod m
                        res_next   = WIDTH'(1);
                        mm_start   = 1'b1;
                        mm_addend  = WIDTH'(1);
                        mm_mult    = base_in;
                        mm_mod     = mod_in;
                        state_next = mexp_pkg::S_RED;
                    end
                end
            end
            mexp_pkg::S_RED:
            begin
                if (mm_done)
                begin
                    pow_next   = mm_product;
                    state_next = mexp_pkg::S_CHECK;
                end
            end
            mexp_pkg::S_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = mexp_pkg::S_DONE;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_addend  = res_reg;
                    state_next = mexp_pkg::S_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = mexp_pkg::S_SQR;
                end
            end
            mexp_pkg::S_MUL:
            begin
                if (mm_done)
                begin
                    res_next   = mm_product;
                    mm_start   = 1'b1;
                    state_next = mexp_pkg::S_SQR;
                end
            end
            mexp_pkg::S_SQR:
            begin
                if (mm_done)
                begin
                    pow_next   = mm_product;
                    exp_next   = {1'b0, exp_reg[WIDTH-1:1]};
                    state_next = mexp_pkg::S_CHECK;
                end
            end
            mexp_pkg::S_DONE:
            begin
                if (!oval_reg || m_tready)
                begin
                    out_next   = res_reg;
                    oval_next  = 1'b1;
                    state_next = mexp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::S_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        pow_reg <= pow_next;
        exp_reg <= exp_next;
        mod_reg <= mod_next;
        out_reg <= out_next;
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .addend  (mm_addend),
        .mult    (mm_mult),
        .modulus (mm_mod),
        .done    (mm_done),
        .product (mm_product)
    );

    assign m_tvalid = oval_reg;
    assign m_tdata  = mexp_pkg::FIELD_W'(out_reg);

endmodule

FILE: hw/rtl/mexp_mulmod.sv
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] addend,
    input  logic [WIDTH-1:0] mult,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] product
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] acc_reg,  acc_next;
    logic [WIDTH-1:0] mult_reg, mult_next;
    logic [WIDTH-1:0] a_reg,    a_next;
    logic [WIDTH-1:0] m_reg,    m_next;
    logic [CW-1:0]    cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH+1:0] red;

    // acc = (2*acc + bit*a) mod m, sum stays below 3m
    always_comb
    begin
        m1  = {2'b00, m_reg};
        m2  = {1'b0, m_reg, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (mult_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        mult_next = mult_reg;
        a_next    = a_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            acc_next  = red[WIDTH-1:0];
            mult_next = {mult_reg[WIDTH-2:0], 1'b0};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            acc_next  = '0;
            mult_next = mult;
            a_next    = addend;
            m_next    = modulus;
            cnt_next  = CW'(WIDTH - 1);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
        a_reg    <= a_next;
        m_reg    <= m_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: hw/rtl/mexp_checker.sv
`include "modular_exponentiation_unit_macros.svh"

module mexp_checker #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [3*mexp_pkg::FIELD_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mexp_pkg::FIELD_W-1:0]   m_tdata
);

    logic in_fire;

    assign in_fire = s_tvalid && s_tready;

    // the unit is busy right after taking a word
    `MEXP_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_tready)

    // a fresh result only appears as the sequencer goes back to idle
    `MEXP_ASSERT_NOW(a_result_from_idle, $rose(m_tvalid), s_tready)

    // result never has bits above the operand width
    `MEXP_ASSERT_NOW(a_result_width, m_tvalid, ((m_tdata >> WIDTH) == '0))

    // a stalled result holds
    `MEXP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a waiting input word holds
    `MEXP_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))

endmodule

bind modular_exponentiation_unit mexp_checker #(
    .WIDTH (WIDTH)
) u_mexp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
